@@ hw/rtl/fqdv_pkg.sv @@
// ----------------------------------------------------------------------------
// fqdv_pkg
// Shared types and constants for the FIFO queue with delete-by-value unit.
// ----------------------------------------------------------------------------
`default_nettype none

package fqdv_pkg;

  // Default queue depth
  localparam int QUEUE_DEPTH = 16;

  // Payload widths
  localparam int VALUE_W  = 32;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_ENQ = 2'd0,
    CMD_DEQ = 2'd1,
    CMD_DEL = 2'd2
  } cmd_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DEQ,
    S_SRCH,
    S_SHIFT,
    S_DONE
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic    take_in;   // latch the input transaction
    logic    enq_wr;    // write value at tail, occupancy up
    logic    rd_head;   // read slot at head
    logic    rd_next;   // read slot at head + k + 1, or head + k + 2 while shifting
    logic    k_clr;
    logic    k_inc;
    logic    shift_wr;  // move read slot into position k
    logic    deq_pop;   // take head value, advance head, occupancy down
    logic    cnt_dec;   // occupancy down after a delete
    logic    res_set;   // set result status and read value
    status_t res_status;
    logic    res_neg1;  // read value of -1
    logic    out_load;  // move result into the output register
  } ctl_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             full;
    logic             empty;
    logic             match;     // read slot equals search value
    logic             more1;     // k + 1 below occupancy
    logic             more2;     // k + 2 below occupancy
    logic             out_free;  // output register can take a result
  } sts_t;

endpackage : fqdv_pkg

`default_nettype wire

@@ hw/rtl/fqdv_ctrl.sv @@
// ----------------------------------------------------------------------------
// fqdv_ctrl
// Controller state machine: sequences enqueue, dequeue, search and compaction.
// ----------------------------------------------------------------------------
`default_nettype none

module fqdv_ctrl (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             in_tvalid,
  output logic            in_tready,
  input  fqdv_pkg::sts_t  sts,
  output fqdv_pkg::ctl_t  ctl
);

  fqdv_pkg::state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fqdv_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt      = state_r;
    ctl            = '0;
    ctl.res_status = fqdv_pkg::STAT_OK;
    in_tready      = 1'b0;
    case (state_r)
      fqdv_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ctl.take_in = 1'b1;
          state_nxt   = fqdv_pkg::S_EXEC;
        end
      end
      fqdv_pkg::S_EXEC: begin
        ctl.res_set = 1'b1;
        ctl.k_clr   = 1'b1;
        state_nxt   = fqdv_pkg::S_DONE;
        case (sts.cmd)
          fqdv_pkg::CMD_ENQ: begin
            if (sts.full) begin
              ctl.res_status = fqdv_pkg::STAT_FULL;
            end else begin
              ctl.enq_wr = 1'b1;
            end
          end
          fqdv_pkg::CMD_DEQ: begin
            if (sts.empty) begin
              ctl.res_status = fqdv_pkg::STAT_EMPTY;
              ctl.res_neg1   = 1'b1;
            end else begin
              ctl.rd_head = 1'b1;
              state_nxt   = fqdv_pkg::S_DEQ;
            end
          end
          fqdv_pkg::CMD_DEL: begin
            if (sts.empty) begin
              ctl.res_status = fqdv_pkg::STAT_NOT_FOUND;
            end else begin
              ctl.rd_head = 1'b1;
              state_nxt   = fqdv_pkg::S_SRCH;
            end
          end
          default: begin
            // unused code: no-op with ok status
          end
        endcase
      end
      fqdv_pkg::S_DEQ: begin
        ctl.deq_pop = 1'b1;
        state_nxt   = fqdv_pkg::S_DONE;
      end
      fqdv_pkg::S_SRCH: begin
        if (sts.match) begin
          if (sts.more1) begin
            ctl.rd_next = 1'b1;
            state_nxt   = fqdv_pkg::S_SHIFT;
          end else begin
            ctl.cnt_dec = 1'b1;
            state_nxt   = fqdv_pkg::S_DONE;
          end
        end else if (sts.more1) begin
          ctl.rd_next = 1'b1;
          ctl.k_inc   = 1'b1;
        end else begin
          ctl.res_set    = 1'b1;
          ctl.res_status = fqdv_pkg::STAT_NOT_FOUND;
          state_nxt      = fqdv_pkg::S_DONE;
        end
      end
      fqdv_pkg::S_SHIFT: begin
        ctl.shift_wr = 1'b1;
        if (sts.more2) begin
          ctl.rd_next = 1'b1;
          ctl.k_inc   = 1'b1;
        end else begin
          ctl.cnt_dec = 1'b1;
          state_nxt   = fqdv_pkg::S_DONE;
        end
      end
      fqdv_pkg::S_DONE: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          state_nxt    = fqdv_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = fqdv_pkg::S_IDLE;
      end
    endcase
  end

endmodule : fqdv_ctrl

`default_nettype wire

@@ hw/rtl/fqdv_dp.sv @@
// ----------------------------------------------------------------------------
// fqdv_dp
// Datapath: circular slot memory, pointers, search compare and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fqdv_dp #(
  parameter int QUEUE_DEPTH = fqdv_pkg::QUEUE_DEPTH
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire  [fqdv_pkg::CMD_W-1:0]          in_cmd,
  input  wire  [fqdv_pkg::VALUE_W-1:0]        in_value,
  input  fqdv_pkg::ctl_t                      ctl,
  output fqdv_pkg::sts_t                      sts,
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  output logic [fqdv_pkg::VALUE_W-1:0]        out_value,
  output logic [fqdv_pkg::STATUS_W-1:0]       out_status,
  output logic [fqdv_pkg::OCC_W-1:0]          out_occ
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int VW = fqdv_pkg::VALUE_W;

  // Wrap a sum of two positions below the depth back into range
  function automatic logic [AW-1:0] wrap_pos(input logic [AW:0] sum);
    logic [AW:0] adj;
    adj = sum;
    if (sum >= (AW+1)'(QUEUE_DEPTH)) begin
      adj = sum - (AW+1)'(QUEUE_DEPTH);
    end
    return adj[AW-1:0];
  endfunction

  // Slot memory
  logic [VW-1:0] slots [QUEUE_DEPTH];
  logic [VW-1:0] mem_q_r;

  logic [AW-1:0]               head_r;
  logic [CW-1:0]               count_r;
  logic [AW-1:0]               k_r;
  logic [fqdv_pkg::CMD_W-1:0]  cmd_r;
  logic [VW-1:0]               val_r;
  logic [VW-1:0]               rd_val_r;
  fqdv_pkg::status_t           status_r;
  logic                        out_tvalid_r;
  logic [VW-1:0]               out_value_r;
  logic [fqdv_pkg::STATUS_W-1:0] out_status_r;
  logic [fqdv_pkg::OCC_W-1:0]  out_occ_r;

  logic [AW-1:0] tail_pos;
  logic [AW-1:0] k_pos;
  logic [AW-1:0] next_pos;
  logic [AW-1:0] far_pos;
  logic [AW-1:0] head_inc;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [VW-1:0] wr_data;
  logic          wr_en;
  logic          rd_en;
  logic [CW:0]   k_ext;
  logic [31:0]   count_wide;

  // Address arithmetic
  assign tail_pos = wrap_pos((AW+1)'(head_r) + (AW+1)'(count_r));
  assign k_pos    = wrap_pos((AW+1)'(head_r) + (AW+1)'(k_r));
  assign next_pos = wrap_pos((AW+1)'(head_r) + (AW+1)'(k_r) + (AW+1)'(1));
  assign far_pos  = wrap_pos((AW+1)'(head_r) + (AW+1)'(k_r) + (AW+1)'(2));
  assign head_inc = wrap_pos((AW+1)'(head_r) + (AW+1)'(1));

  // While shifting, slot k + 1 is already held, so the walk fetches k + 2
  assign rd_en   = ctl.rd_head | ctl.rd_next;
  assign rd_addr = ctl.rd_head ? head_r : (ctl.shift_wr ? far_pos : next_pos);
  assign wr_en   = ctl.enq_wr | ctl.shift_wr;
  assign wr_addr = ctl.enq_wr ? tail_pos : k_pos;
  assign wr_data = ctl.enq_wr ? val_r : mem_q_r;

  // Memory write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q_r <= slots[rd_addr];
    end
  end

  // Status to the controller
  assign k_ext        = (CW+1)'(k_r);
  assign sts.cmd      = cmd_r;
  assign sts.full     = (count_r == CW'(QUEUE_DEPTH));
  assign sts.empty    = (count_r == '0);
  assign sts.match    = (mem_q_r == val_r);
  assign sts.more1    = ((k_ext + (CW+1)'(1)) < (CW+1)'(count_r));
  assign sts.more2    = ((k_ext + (CW+1)'(2)) < (CW+1)'(count_r));
  assign sts.out_free = ~out_tvalid_r | out_tready;

  // Queue control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
      k_r     <= '0;
    end else begin
      if (ctl.enq_wr) begin
        count_r <= count_r + CW'(1);
      end else if (ctl.deq_pop || ctl.cnt_dec) begin
        count_r <= count_r - CW'(1);
      end
      if (ctl.deq_pop) begin
        head_r <= head_inc;
      end
      if (ctl.k_clr) begin
        k_r <= '0;
      end else if (ctl.k_inc) begin
        k_r <= k_r + AW'(1);
      end
    end
  end

  // Transaction and result payload
  always_ff @(posedge clk) begin
    if (ctl.take_in) begin
      cmd_r <= in_cmd;
      val_r <= in_value;
    end
    if (ctl.res_set) begin
      status_r <= ctl.res_status;
      rd_val_r <= ctl.res_neg1 ? '1 : '0;
    end
    if (ctl.deq_pop) begin
      rd_val_r <= mem_q_r;
    end
  end

  // Output register
  assign count_wide = 32'(count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (ctl.out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_value_r  <= rd_val_r;
      out_status_r <= status_r;
      out_occ_r    <= count_wide[fqdv_pkg::OCC_W-1:0];
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;
  assign out_occ    = out_occ_r;

endmodule : fqdv_dp

`default_nettype wire

@@ hw/rtl/fifo_queue_with_delete_by_value_unit.sv @@
// ----------------------------------------------------------------------------
// fifo_queue_with_delete_by_value_unit
// Bounded FIFO of signed 32-bit values with remove-first-match.
// ----------------------------------------------------------------------------
// Usage:
//   One command transaction enters on the in_ stream (in_tuser = command,
//   in_tdata = item value) and gives exactly one result on the out_ stream
//   (out_tdata = read value and occupancy, out_tuser = status).
//   Commands are handled one at a time; in_tready is high only while the
//   controller is idle.
// Controller steps, from acceptance to out_tvalid:
//   enqueue, empty dequeue, empty delete, unused code : S_EXEC, S_DONE
//   dequeue                                           : S_EXEC, S_DEQ, S_DONE
//   delete : S_EXEC, then S_SRCH for each slot searched up to the match,
//   then S_SHIFT for each entry moved up behind it, then S_DONE.
//   The delete time is set by the single read and single write port of the slot
//   memory, which the search and the gap-closing walk go through one slot
//   per cycle. The next command is taken once the result is loaded.
// Reset: occupancy clears to zero, the queue is empty; slot contents are
//   left as they are and are never read before being written.
// Stall: a result waits in the output register while out_tready is low;
//   the next command may be accepted and is worked, then held until the
//   output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module fifo_queue_with_delete_by_value_unit #(
  parameter int QUEUE_DEPTH = fqdv_pkg::QUEUE_DEPTH
) (
  input  wire         clk,
  input  wire         rst_n,
  // command channel
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [31:0] in_tdata,   // [31:0] item_value
  input  wire  [1:0]  in_tuser,   // [1:0] command
  // result channel
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [39:0] out_tdata,  // [31:0] read_value, [36:32] occupancy, [39:37] zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  fqdv_pkg::ctl_t ctl;
  fqdv_pkg::sts_t sts;

  logic [fqdv_pkg::VALUE_W-1:0]  out_value;
  logic [fqdv_pkg::STATUS_W-1:0] out_status;
  logic [fqdv_pkg::OCC_W-1:0]    out_occ;

  // Controller
  fqdv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .ctl       (ctl)
  );

  // Datapath
  fqdv_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_cmd     (in_tuser),
    .in_value   (in_tdata),
    .ctl        (ctl),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_value  (out_value),
    .out_status (out_status),
    .out_occ    (out_occ)
  );

  // Output packing
  assign out_tdata = {3'b000, out_occ, out_value};
  assign out_tuser = out_status;

endmodule : fifo_queue_with_delete_by_value_unit

`default_nettype wire
